@@ hdl/epoch_seconds_to_bcd_calendar_core_defines.svh @@
// Assertion helpers shared by the calendar core.
`ifndef EPOCH_SECONDS_TO_BCD_CALENDAR_CORE_DEFINES_SVH
`define EPOCH_SECONDS_TO_BCD_CALENDAR_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ECAL_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ECAL_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/ecal_pkg.sv @@
`timescale 1ns / 1ps
package ecal_pkg;

  // Micro-operations.
  localparam logic [3:0] OP_DAY     = 4'd0;
  localparam logic [3:0] OP_TOD     = 4'd1;
  localparam logic [3:0] OP_HOUR    = 4'd2;
  localparam logic [3:0] OP_HREM    = 4'd3;
  localparam logic [3:0] OP_MIN     = 4'd4;
  localparam logic [3:0] OP_SEC     = 4'd5;
  localparam logic [3:0] OP_WEEK    = 4'd6;
  localparam logic [3:0] OP_LD_YEAR = 4'd7;
  localparam logic [3:0] OP_YEAR    = 4'd8;
  localparam logic [3:0] OP_MONTH   = 4'd9;
  localparam logic [3:0] OP_END     = 4'd10;

  // Jump conditions.
  localparam logic [1:0] COND_NEVER = 2'd0;
  localparam logic [1:0] COND_YFIT  = 2'd1;
  localparam logic [1:0] COND_MFIT  = 2'd2;

  localparam int PC_W = 4;
  localparam logic [PC_W-1:0] PC_LAST = 4'd10;

  localparam logic [31:0] SECS_PER_DAY  = 32'd86400;
  localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
  localparam logic [11:0] SECS_PER_MIN  = 12'd60;
  localparam logic [15:0] DAYS_PER_WEEK = 16'd7;

  // Quotients by reciprocal multiplication. The power-of-two part of each
  // divisor is dropped first; the reciprocals are rounded up, and the error
  // stays below one unit over the whole input range.
  // Days: (secs >> 7) / 675, reciprocal 2^35 / 675.
  localparam logic [25:0] DAY_RECIP  = 26'd50903317;
  // Hours: (tod >> 4) / 225, reciprocal 2^20 / 225.
  localparam logic [12:0] HOUR_RECIP = 13'd4661;
  // Minutes: (rest >> 2) / 15, reciprocal 2^14 / 15.
  localparam logic [10:0] MIN_RECIP  = 11'd1093;
  // Weeks: n / 7, reciprocal 2^19 / 7.
  localparam logic [16:0] WDAY_RECIP = 17'd74899;
  // 1970-01-01 was a Thursday.
  localparam logic [15:0] WDAY_BIAS = 16'd3;

  // Years are kept as an offset from 1970.
  localparam logic [7:0] YOFF_2000 = 8'd30;
  localparam logic [7:0] YOFF_2099 = 8'd129;
  localparam logic [7:0] YOFF_2100 = 8'd130;
  localparam logic [3:0] DECEMBER  = 4'd12;

  typedef struct packed {
    logic [3:0]      op;
    logic [1:0]      cond;
    logic [PC_W-1:0] target;
  } uword_t;

  typedef struct packed {
    logic   run;
    uword_t uw;
  } ctl_t;

  typedef struct packed {
    logic yfit;
    logic mfit;
  } stat_t;

  typedef struct packed {
    logic [7:0] year_bcd;
    logic [4:0] month_bcd;
    logic [5:0] date_bcd;
    logic [2:0] weekday;
    logic [5:0] hour_bcd;
    logic [6:0] minute_bcd;
    logic [6:0] second_bcd;
    logic       year_out_of_range;
  } res_t;

  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    unique case (pc)
      4'd0:    w = '{OP_DAY,     COND_NEVER, 4'd0};
      4'd1:    w = '{OP_TOD,     COND_NEVER, 4'd0};
      4'd2:    w = '{OP_HOUR,    COND_NEVER, 4'd0};
      4'd3:    w = '{OP_HREM,    COND_NEVER, 4'd0};
      4'd4:    w = '{OP_MIN,     COND_NEVER, 4'd0};
      4'd5:    w = '{OP_SEC,     COND_NEVER, 4'd0};
      4'd6:    w = '{OP_WEEK,    COND_NEVER, 4'd0};
      4'd7:    w = '{OP_LD_YEAR, COND_NEVER, 4'd0};
      4'd8:    w = '{OP_YEAR,    COND_YFIT,  4'd8};
      4'd9:    w = '{OP_MONTH,   COND_MFIT,  4'd9};
      default: w = '{OP_END,     COND_NEVER, 4'd0};
    endcase
    return w;
  endfunction

  // Leap rule over 1970..2106, where 2000 is the only century leap year.
  function automatic logic leap_off(input logic [7:0] yoff);
    return (2'(yoff[1:0] + 2'd2) == 2'd0) && (yoff != YOFF_2100);
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    unique case (m)
      4'd2:                   len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      default:                len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic logic [6:0] year_mod100(input logic [7:0] yoff);
    logic [6:0] v;
    if (yoff < YOFF_2000) begin
      v = 7'(yoff + 8'd70);
    end else if (yoff < YOFF_2100) begin
      v = 7'(yoff - YOFF_2000);
    end else begin
      v = 7'(yoff - YOFF_2100);
    end
    return v;
  endfunction

  // Two BCD digits of a value below 100; tens by reciprocal multiply.
  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [13:0] prod;
    logic [3:0]  tens;
    logic [3:0]  ones;
    prod = 14'(v) * 14'd103;
    tens = prod[13:10];
    ones = 4'(v - 7'(tens) * 7'd10);
    return {tens, ones};
  endfunction

endpackage

@@ hdl/epoch_seconds_to_bcd_calendar_core.sv @@
`timescale 1ns / 1ps
// Converts a count of seconds since 1970-01-01 00:00:00 into a packed-BCD
// calendar date and time of day, with a day of week from 1 (Monday) to 7.
// The input channel carries epoch_seconds under in_valid / in_ready; each
// transfer produces exactly one result on the output channel under
// out_valid / out_ready, with every calendar field a port of its own.
// A small microprogram takes days, hours, minutes and the weekday by
// reciprocal multiplication, one product per step, then walks years one per
// cycle and months one per cycle. One item is in work at a time and the
// input is ready again the cycle after the result is written. The result
// sits in an output register, so a new input is taken as soon as the
// previous item finishes, even while its result still waits. If the
// receiver stalls, the next item runs up to its final step and waits there
// until the output register is free. Synchronous reset clears the
// sequencer and out_valid; the block is then ready for input.
module epoch_seconds_to_bcd_calendar_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] epoch_seconds,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  year_bcd,
  output logic [4:0]  month_bcd,
  output logic [5:0]  date_bcd,
  output logic [2:0]  weekday,
  output logic [5:0]  hour_bcd,
  output logic [6:0]  minute_bcd,
  output logic [6:0]  second_bcd,
  output logic        year_out_of_range
);
  import ecal_pkg::*;

  ctl_t  ctl;
  stat_t stat;
  res_t  res;
  logic  done;
  logic  out_free;

  assign out_free = !out_valid || out_ready;

  ecal_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_free (out_free),
    .stat     (stat),
    .ctl      (ctl),
    .done     (done)
  );

  ecal_dp u_dp (
    .clk           (clk),
    .load          (in_valid && in_ready),
    .epoch_seconds (epoch_seconds),
    .ctl           (ctl),
    .stat          (stat),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      year_bcd          <= res.year_bcd;
      month_bcd         <= res.month_bcd;
      date_bcd          <= res.date_bcd;
      weekday           <= res.weekday;
      hour_bcd          <= res.hour_bcd;
      minute_bcd        <= res.minute_bcd;
      second_bcd        <= res.second_bcd;
      year_out_of_range <= res.year_out_of_range;
    end
  end

endmodule

@@ hdl/ecal_seq.sv @@
`timescale 1ns / 1ps
`include "epoch_seconds_to_bcd_calendar_core_defines.svh"
module ecal_seq (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            out_free,
  input  ecal_pkg::stat_t stat,
  output ecal_pkg::ctl_t  ctl,
  output logic            done
);
  import ecal_pkg::*;

  logic            busy;
  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  uword_t          uw;
  logic            take;

  assign uw       = ucode(pc);
  assign in_ready = !busy;
  assign done     = busy && (uw.op == OP_END) && out_free;
  assign ctl.run  = busy;
  assign ctl.uw   = uw;

  always_comb begin
    unique case (uw.cond)
      COND_YFIT: take = stat.yfit;
      COND_MFIT: take = stat.mfit;
      default:   take = 1'b0;
    endcase
    pc_next = take ? uw.target : PC_W'(pc + 1'b1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= '0;
    end else if (!busy) begin
      if (in_valid) begin
        busy <= 1'b1;
        pc   <= '0;
      end
    end else if (uw.op == OP_END) begin
      // Hold on the final step until the output register can take the result.
      if (out_free) begin
        busy <= 1'b0;
      end
    end else begin
      pc <= pc_next;
    end
  end

  `ECAL_ASSERT_NEXT(a_start, clk, rst, in_valid && in_ready, busy && (pc == '0), "start not at step zero")
  `ECAL_ASSERT_IMP(a_pc_range, clk, rst, busy, pc <= PC_LAST, "step counter out of program")
  `ECAL_ASSERT_NEXT(a_end, clk, rst, done, !busy, "sequencer still busy after result")
  `ECAL_ASSERT_NEXT(a_hold, clk, rst, busy && (uw.op == OP_END) && !out_free, busy && $stable(pc), "final step left while output blocked")

endmodule

@@ hdl/ecal_dp.sv @@
`timescale 1ns / 1ps
module ecal_dp (
  input  logic            clk,
  input  logic            load,
  input  logic [31:0]     epoch_seconds,
  input  ecal_pkg::ctl_t  ctl,
  output ecal_pkg::stat_t stat,
  output ecal_pkg::res_t  res
);
  import ecal_pkg::*;

  logic [31:0] secs;
  logic [15:0] days;
  logic [16:0] tod;
  logic [4:0]  hour;
  logic [11:0] mrem;
  logic [5:0]  minute;
  logic [5:0]  second;
  logic [12:0] wq;
  logic [2:0]  wday;
  logic [15:0] rem;
  logic [7:0]  year;
  logic [3:0]  month;

  logic [50:0] day_prod;
  logic [31:0] day_base;
  logic [24:0] hour_prod;
  logic [16:0] hour_base;
  logic [19:0] min_prod;
  logic [11:0] min_base;
  logic [15:0] wk_num;
  logic [31:0] wq_prod;
  logic [15:0] wk_base;
  logic        leap;
  logic [8:0]  ylen;
  logic [4:0]  mlen;

  // Each product is taken into a register in its own step.
  assign day_prod  = 51'(secs[31:7]) * 51'(DAY_RECIP);
  assign day_base  = 32'(days) * SECS_PER_DAY;
  assign hour_prod = 25'(tod[16:4]) * 25'(HOUR_RECIP);
  assign hour_base = 17'(hour) * SECS_PER_HOUR;
  assign min_prod  = 20'(mrem[11:2]) * 20'(MIN_RECIP);
  assign min_base  = 12'(minute) * SECS_PER_MIN;
  assign wk_num    = days + WDAY_BIAS;
  assign wq_prod   = 32'(wk_num) * 32'(WDAY_RECIP);
  assign wk_base   = 16'(wq) * DAYS_PER_WEEK;

  assign leap = leap_off(year);
  assign ylen = leap ? 9'd366 : 9'd365;
  assign mlen = month_len(month, leap);

  assign stat.yfit = rem >= 16'(ylen);
  assign stat.mfit = (rem >= 16'(mlen)) && (month != DECEMBER);

  always_ff @(posedge clk) begin
    if (load) begin
      secs <= epoch_seconds;
    end
    if (ctl.run) begin
      unique case (ctl.uw.op)
        OP_DAY: begin
          days <= day_prod[50:35];
        end
        OP_TOD: begin
          tod <= 17'(secs - day_base);
        end
        OP_HOUR: begin
          hour <= hour_prod[24:20];
        end
        OP_HREM: begin
          mrem <= 12'(tod - hour_base);
        end
        OP_MIN: begin
          minute <= min_prod[19:14];
        end
        OP_SEC: begin
          second <= 6'(mrem - min_base);
        end
        OP_WEEK: begin
          wq <= wq_prod[31:19];
        end
        OP_LD_YEAR: begin
          wday  <= 3'(wk_num - wk_base);
          rem   <= days;
          year  <= '0;
          month <= 4'd1;
        end
        OP_YEAR: begin
          if (stat.yfit) begin
            rem  <= rem - 16'(ylen);
            year <= 8'(year + 1'b1);
          end
        end
        OP_MONTH: begin
          if (stat.mfit) begin
            rem   <= rem - 16'(mlen);
            month <= 4'(month + 1'b1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    res.year_bcd          = to_bcd(year_mod100(year));
    res.month_bcd         = 5'(to_bcd(7'(month)));
    res.date_bcd          = 6'(to_bcd(7'(rem[4:0]) + 7'd1));
    res.weekday           = 3'(wday + 1'b1);
    res.hour_bcd          = 6'(to_bcd(7'(hour)));
    res.minute_bcd        = 7'(to_bcd(7'(minute)));
    res.second_bcd        = 7'(to_bcd(7'(second)));
    res.year_out_of_range = (year < YOFF_2000) || (year > YOFF_2099);
  end

endmodule
